/* rtl/ncma_pkg.sv */
`default_nettype none
package ncma_pkg;

    localparam int WINDOW   = 16;
    localparam int NCHAN    = 9;
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W    = SAMPLE_W + IDX_W;
    localparam int DATA_W   = NCHAN * SAMPLE_W;

    // per-cycle control shared by all lanes
    typedef struct packed {
        logic             acc;   // sample request taken this cycle
        logic             adv;   // sum stage updates this cycle
        logic [IDX_W-1:0] idx;   // ring slot being replaced
    } lane_ctrl_t;

endpackage
`default_nettype wire

/* rtl/ncma_lane.sv */
`default_nettype none
module ncma_lane (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire ncma_pkg::lane_ctrl_t                 ctrl,
    input  wire logic signed [ncma_pkg::SAMPLE_W-1:0] sample,
    output logic signed [ncma_pkg::SAMPLE_W-1:0]      mean_next
);
    import ncma_pkg::*;

    logic signed [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [WINDOW-1:0]          vld_reg;
    logic signed [SAMPLE_W-1:0] old_reg;
    logic                       old_vld_reg;
    logic signed [SAMPLE_W-1:0] new_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    old_ext;
    logic signed [SUM_W-1:0]    new_ext;

    // read-first ring: old entry leaves as the new one lands
    always_ff @(posedge aclk) begin
        if (ctrl.acc) begin
            old_reg             <= ring_mem[ctrl.idx];
            old_vld_reg         <= vld_reg[ctrl.idx];
            ring_mem[ctrl.idx]  <= sample;
            new_reg             <= sample;
        end
    end

    // slots never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctrl.acc) begin
            vld_reg[ctrl.idx] <= 1'b1;
        end
    end

    always_comb begin
        old_ext  = old_vld_reg ? {{IDX_W{old_reg[SAMPLE_W-1]}}, old_reg} : '0;
        new_ext  = {{IDX_W{new_reg[SAMPLE_W-1]}}, new_reg};
        sum_next = sum_reg - old_ext + new_ext;
        // floor shift by log2 of the window
        mean_next = sum_next[IDX_W +: SAMPLE_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.adv) begin
            sum_reg <= sum_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/nine_channel_moving_average.sv */
// nine-channel boxcar moving average
//
// s_ channel: one nine-axis sensor sample per request, packed in s_tdata as
// nine signed 16-bit channels (accel x/y/z, gyro x/y/z, mag x/y/z, lowest
// bits first). m_ channel: one result per request, the window mean of each
// channel in the same order, rounded toward minus infinity.
//
// each channel runs in its own lane: a ring of the last WINDOW samples and a
// running sum that drops the overwritten entry and adds the new one. the
// lane outputs are merged into one output register.
//
// an accepted request passes the ring-read stage, then the sum update into the
// output register, before m_tvalid rises. throughput: one request per cycle
// while m_tready keeps the output register draining.
//
// reset (aresetn low, synchronous) empties the pipeline, clears the sums and the
// ring valid bits, so the mean ramps up from zero over the first WINDOW samples.
// when the receiver stalls, the output register holds, one more request can
// sit in the ring-read stage, then s_tready drops until m_tready returns.
`default_nettype none
module nine_channel_moving_average (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z
    input  wire logic [ncma_pkg::DATA_W-1:0]        s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // mean_accel_x, mean_accel_y, mean_accel_z, mean_gyro_x, mean_gyro_y,
    // mean_gyro_z, mean_mag_x, mean_mag_y, mean_mag_z
    output logic [ncma_pkg::DATA_W-1:0]             m_tdata
);
    import ncma_pkg::*;

    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

    logic              a_valid_reg;    // request sitting in the ring-read stage
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic [DATA_W-1:0] m_tdata_next;
    logic [IDX_W-1:0]  idx_reg;        // ring slot the next sample replaces
    logic              b_adv;          // output register free or emptying
    logic              accept;
    lane_ctrl_t        ctrl;
    logic signed [SAMPLE_W-1:0] lane_mean [NCHAN];

    assign b_adv    = !m_tvalid_reg || m_tready;
    assign s_tready = !a_valid_reg || b_adv;
    assign accept   = s_tvalid && s_tready;

    assign ctrl.acc = accept;
    assign ctrl.adv = a_valid_reg && b_adv;
    assign ctrl.idx = idx_reg;

    // one lane per sensor channel
    for (genvar c = 0; c < NCHAN; c++) begin : g_lane
        ncma_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .sample    (s_tdata[c*SAMPLE_W +: SAMPLE_W]),
            .mean_next (lane_mean[c])
        );
    end

    // merge lane means into the result word
    always_comb begin
        for (int c = 0; c < NCHAN; c++) begin
            m_tdata_next[c*SAMPLE_W +: SAMPLE_W] = lane_mean[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_adv) begin
                m_tvalid_reg <= a_valid_reg;
            end
            if (accept) begin
                // wraps at the window size
                idx_reg <= idx_reg + IDX_ONE;
            end
        end
    end

    // result register only loads when a sum update is taken
    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // stalled ring-read stage keeps its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !b_adv |=> a_valid_reg)
        else $error("ring-read stage lost a request under stall");

    // every accepted request moves the ring slot by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> idx_reg == $past(idx_reg) + IDX_ONE)
        else $error("ring slot did not advance on accept");

    // a request leaving the ring-read stage shows up as a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && b_adv |=> m_tvalid_reg)
        else $error("result missing after sum update");

    // reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid_reg)
        else $error("result valid right after reset");

endmodule
`default_nettype wire
